@@ sv/yti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yti_pkg
// Shared types and constants for the YUYV to I420 write generator.
// ----------------------------------------------------------------------------
`default_nettype none

package yti_pkg;

    localparam int DIM_W        = 13;   // frame dimension registers
    localparam int CNT_W        = 12;   // row / column counters
    localparam int LUMA_IDX_W   = 24;
    localparam int CHROMA_IDX_W = 22;
    localparam int BYTE_W       = 8;
    localparam int CFG_ADDR_W   = 8;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 80;
    localparam int M_USER_W     = 2;

    localparam logic [DIM_W-1:0] MAX_DIM          = 13'd4096;
    localparam logic [DIM_W-1:0] WIDTH_RESET      = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET     = 13'd480;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

    typedef struct packed {
        logic [LUMA_IDX_W-1:0]   luma_index;
        logic [CHROMA_IDX_W-1:0] chroma_index;
        logic                    second_valid;
        logic                    chroma_valid;
        logic                    frame_last;
    } pos_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/yuyv_to_i420_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_i420_converter
// Turns a raster stream of YUYV macropixels into planar 4:2:0 writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one YUYV macropixel per transaction, raster order over the
//   active frame, stride padding already removed.
//   m_ channel: one write transaction per macropixel: luma offset with Y0/Y1,
//   and on even rows, where Y1 lies in the row, a U/V pair with its chroma
//   offset. m_tlast marks the last macropixel of the frame.
//   cfg port: frame_width (index 0) and frame_height (index 1); write only
//   while the stream is idle. cfg_ready is always high.
//   The result is registered: valid in the cycle after the input transaction;
//   one macropixel per cycle is sustained while m_tready is high. The offset
//   multipliers sit between the row/column counters and the result register.
//   A stalled receiver holds the result register; s_tready drops only while
//   a result is held and m_tready is low.
//   Reset clears the counters to the top-left pixel, empties the result
//   register and loads 640 x 480.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_i420_converter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: luma_first[7:0], chroma_blue[15:8], luma_second[23:16],
    //          chroma_red[31:24]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [yti_pkg::S_DATA_W-1:0]   s_tdata,
    // m_tdata: luma_index[23:0], luma_out_first[31:24], luma_out_second[39:32],
    //          chroma_index[61:40], u_out[69:62], v_out[77:70], zero[79:78]
    // m_tuser: second_valid[0], chroma_valid[1]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [yti_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [yti_pkg::M_USER_W-1:0]        m_tuser,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [yti_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [yti_pkg::DIM_W-1:0]      cfg_wdata
);

    yti_pkg::dims_t dims;
    yti_pkg::pos_t  pos;
    logic           accept;

    assign cfg_ready = 1'b1;

    yti_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .dims      (dims)
    );

    yti_pos u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dims    (dims),
        .advance (accept),
        .pos     (pos)
    );

    yti_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pos      (pos),
        .accept   (accept),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ sv/yti_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yti_cfg
// Frame dimension registers; values are stored already clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [yti_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [yti_pkg::DIM_W-1:0]      cfg_wdata,
    output yti_pkg::dims_t                      dims
);

    yti_pkg::dims_t dims_reg;
    yti_pkg::dims_t dims_next;

    always_comb begin
        dims_next = dims_reg;
        if (cfg_valid) begin
            if (cfg_addr == yti_pkg::REG_FRAME_WIDTH) begin
                dims_next.width = yti_pkg::clamp_dim(cfg_wdata);
            end else if (cfg_addr == yti_pkg::REG_FRAME_HEIGHT) begin
                dims_next.height = yti_pkg::clamp_dim(cfg_wdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.width  <= yti_pkg::WIDTH_RESET;
            dims_reg.height <= yti_pkg::HEIGHT_RESET;
        end else begin
            dims_reg <= dims_next;
        end
    end

    assign dims = dims_reg;

endmodule

`default_nettype wire

@@ sv/yti_pos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yti_pos
// Row/column counters and plane offsets of the current macropixel.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_pos (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire yti_pkg::dims_t dims,
    input  wire logic   advance,
    output yti_pkg::pos_t  pos
);

    localparam int CMP_W = yti_pkg::DIM_W + 1;
    localparam int LP_W  = yti_pkg::LUMA_IDX_W + 1;

    logic [yti_pkg::CNT_W-1:0] row_reg, row_next;
    logic [yti_pkg::CNT_W-1:0] col_reg, col_next;

    logic                             second, row_end, last_row;
    logic [LP_W-1:0]                  luma_sum;
    logic [yti_pkg::CHROMA_IDX_W-1:0] chroma_sum;

    always_comb begin
        second   = (CMP_W'(col_reg) + CMP_W'(1)) < CMP_W'(dims.width);
        row_end  = (CMP_W'(col_reg) + CMP_W'(2)) >= CMP_W'(dims.width);
        last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(dims.height);

        // offsets follow the live width, so a width change keeps them consistent
        luma_sum   = LP_W'(row_reg) * LP_W'(dims.width) + LP_W'(col_reg);
        chroma_sum = yti_pkg::CHROMA_IDX_W'(row_reg[yti_pkg::CNT_W-1:1])
                   * yti_pkg::CHROMA_IDX_W'(dims.width[yti_pkg::DIM_W-1:1])
                   + yti_pkg::CHROMA_IDX_W'(col_reg[yti_pkg::CNT_W-1:1]);

        pos.luma_index   = luma_sum[yti_pkg::LUMA_IDX_W-1:0];
        pos.chroma_index = chroma_sum;
        pos.second_valid = second;
        pos.chroma_valid = second && !row_reg[0];
        pos.frame_last   = row_end && last_row;

        row_next = row_reg;
        col_next = col_reg;
        if (advance) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + yti_pkg::CNT_W'(1);
            end else begin
                col_next = col_reg + yti_pkg::CNT_W'(2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/yti_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yti_out
// Result register: packs one write transaction and holds it under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module yti_out (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [yti_pkg::S_DATA_W-1:0] s_tdata,
    input  wire yti_pkg::pos_t                pos,
    output logic                              accept,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [yti_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [yti_pkg::M_USER_W-1:0]      m_tuser,
    output logic                              m_tlast
);

    logic                              valid_reg, valid_next;
    logic [yti_pkg::M_DATA_W-1:0]      data_reg, data_next;
    logic [yti_pkg::M_USER_W-1:0]      user_reg, user_next;
    logic                              last_reg, last_next;

    logic [yti_pkg::BYTE_W-1:0] y0, u, y1, v;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        y0 = s_tdata[7:0];
        u  = s_tdata[15:8];
        y1 = s_tdata[23:16];
        v  = s_tdata[31:24];

        data_next = '0;
        data_next[23:0]  = pos.luma_index;
        data_next[31:24] = y0;
        data_next[39:32] = pos.second_valid ? y1 : '0;
        data_next[61:40] = pos.chroma_valid ? pos.chroma_index : '0;
        data_next[69:62] = pos.chroma_valid ? u : '0;
        data_next[77:70] = pos.chroma_valid ? v : '0;
        user_next = {pos.chroma_valid, pos.second_valid};
        last_next = pos.frame_last;

        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the YUYV to I420 write generator.
// A directed table covers reset geometry, field extremes, odd widths,
// zero and oversized dimensions and geometry changes in mid-frame.
// Random bursts follow under three handshake idling patterns. Each plane
// write is checked field by field against an in-bench model of the counters.
// ----------------------------------------------------------------------------

module tb;
    import yti_pkg::*;

    localparam int STALL_LIMIT = 4000;  // cycles with no transaction at all
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 260;
    localparam int DRAIN_WAIT  = 8;

    // index outside the register map; the write must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] chroma_red;
        logic [BYTE_W-1:0] luma_second;
        logic [BYTE_W-1:0] chroma_blue;
        logic [BYTE_W-1:0] luma_first;
    } macropixel_t;

    typedef struct packed {
        logic [LUMA_IDX_W-1:0]   luma_index;
        logic [BYTE_W-1:0]       luma_out_first;
        logic [BYTE_W-1:0]       luma_out_second;
        logic                    second_valid;
        logic [CHROMA_IDX_W-1:0] chroma_index;
        logic [BYTE_W-1:0]       u_out;
        logic [BYTE_W-1:0]       v_out;
        logic                    chroma_valid;
        logic                    frame_last;
    } plane_write_t;

    typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [DIM_W-1:0]       value;
        macropixel_t            mp;
        bit                     typed;
        plane_write_t           want;
    } step_t;

    typedef struct {
        bit           typed;
        plane_write_t want;
    } known_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_DATA_W-1:0]      s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_DATA_W-1:0]      m_tdata;
    logic [M_USER_W-1:0]      m_tuser;
    logic                     m_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_W-1:0]    cfg_addr  = '0;
    logic [DIM_W-1:0]         cfg_wdata = '0;

    // model copy of registers and raster position
    logic [DIM_W-1:0]  reg_width  = WIDTH_RESET;
    logic [DIM_W-1:0]  reg_height = HEIGHT_RESET;
    logic [CNT_W-1:0]  pos_row    = '0;
    logic [CNT_W-1:0]  pos_col    = '0;

    plane_write_t plane_q[$];
    known_t       known_q[$];
    step_t        directed_q[$];

    int send_idle = 0;
    int recv_idle = 0;
    int stall_cycles = 0;
    int n_macropixels = 0;
    int n_writes = 0;
    int n_chroma = 0;
    int n_frames = 0;
    int n_reg_writes = 0;
    int n_mismatch = 0;

    yuyv_to_i420_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic int unsigned active_dim(input logic [DIM_W-1:0] v);
        return (v == '0) ? 1 : ((v > MAX_DIM) ? int'(MAX_DIM) : int'(v));
    endfunction

    // plane write for one macropixel; advances the raster position
    function automatic plane_write_t next_plane_write(input macropixel_t mp);
        int unsigned  w, h, col, row;
        bit           in_row, row_end, last_row;
        plane_write_t pw;
        w        = active_dim(reg_width);
        h        = active_dim(reg_height);
        col      = pos_col;
        row      = pos_row;
        in_row   = (col + 1) < w;
        row_end  = (col + 2) >= w;
        last_row = (row + 1) >= h;
        pw = '0;
        pw.luma_index     = LUMA_IDX_W'(row * w + col);
        pw.luma_out_first = mp.luma_first;
        if (in_row) begin
            pw.luma_out_second = mp.luma_second;
            pw.second_valid    = 1'b1;
            if (row % 2 == 0) begin
                pw.chroma_index = CHROMA_IDX_W'((row / 2) * (w / 2) + col / 2);
                pw.u_out        = mp.chroma_blue;
                pw.v_out        = mp.chroma_red;
                pw.chroma_valid = 1'b1;
            end
        end
        pw.frame_last = row_end && last_row;
        if (row_end) begin
            pos_col = '0;
            pos_row = last_row ? '0 : CNT_W'(row + 1);
        end else begin
            pos_col = CNT_W'(col + 2);
        end
        return pw;
    endfunction

    function automatic string fmt_write(input plane_write_t pw);
        return $sformatf("luma %06h y %02h/%02h sv %0b chroma %06h uv %02h/%02h cv %0b last %0b",
                         pw.luma_index, pw.luma_out_first, pw.luma_out_second,
                         pw.second_valid, pw.chroma_index, pw.u_out, pw.v_out,
                         pw.chroma_valid, pw.frame_last);
    endfunction

    function automatic void report_mismatch(input string what, input plane_write_t want,
                                            input plane_write_t got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("[%0t] %s on write %0d", $realtime, what, n_writes);
            $display("    expected %s", fmt_write(want));
            $display("    actual   %s", fmt_write(got));
        end
    endfunction

    always @(posedge aclk) begin : monitor
        plane_write_t got, want;
        known_t       k;
        if (!aresetn) begin
            reg_width    = WIDTH_RESET;
            reg_height   = HEIGHT_RESET;
            pos_row      = '0;
            pos_col      = '0;
            stall_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.luma_index      = m_tdata[23:0];
                got.luma_out_first  = m_tdata[31:24];
                got.luma_out_second = m_tdata[39:32];
                got.chroma_index    = m_tdata[61:40];
                got.u_out           = m_tdata[69:62];
                got.v_out           = m_tdata[77:70];
                got.second_valid    = m_tuser[0];
                got.chroma_valid    = m_tuser[1];
                got.frame_last      = m_tlast;
                n_writes++;
                if (got.chroma_valid === 1'b1) n_chroma++;
                if (got.frame_last === 1'b1) n_frames++;
                if (plane_q.size() == 0) begin
                    report_mismatch("unexpected write", '0, got);
                end else begin
                    want = plane_q.pop_front();
                    if (got !== want) report_mismatch("mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready) begin
                n_reg_writes++;
                case (cfg_addr)
                    REG_FRAME_WIDTH:  reg_width  = cfg_wdata;
                    REG_FRAME_HEIGHT: reg_height = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = next_plane_write(macropixel_t'(s_tdata));
                if (known_q.size() != 0) begin
                    k = known_q.pop_front();
                    if (k.typed) want = k.want;
                end
                plane_q.insert(plane_q.size(), want);
                n_macropixels++;
            end
            if ((m_tvalid && m_tready) || (cfg_valid && cfg_ready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[%0t] no transaction for %0d cycles, %0d writes outstanding",
                 $realtime, STALL_LIMIT, plane_q.size());
        $display("FAIL");
        $finish;
    end

    function automatic void add_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [DIM_W-1:0] value);
        step_t s;
        s = '{kind: STEP_REG, addr: addr, value: value, mp: '0, typed: 1'b0, want: '0};
        directed_q.insert(directed_q.size(), s);
    endfunction

    function automatic void add_pixel(input logic [S_DATA_W-1:0] px);
        step_t s;
        s = '{kind: STEP_PIXEL, addr: '0, value: '0, mp: px, typed: 1'b0, want: '0};
        directed_q.insert(directed_q.size(), s);
    endfunction

    function automatic void add_known(input logic [S_DATA_W-1:0] px,
                                      input logic [LUMA_IDX_W-1:0] luma,
                                      input logic [7:0] y0, input logic [7:0] y1,
                                      input logic sv, input logic [CHROMA_IDX_W-1:0] ci,
                                      input logic [7:0] u, input logic [7:0] v,
                                      input logic cv, input logic last);
        step_t s;
        s = '{kind: STEP_PIXEL, addr: '0, value: '0, mp: px, typed: 1'b1, want: '0};
        s.want = '{luma, y0, y1, sv, ci, u, v, cv, last};
        directed_q.insert(directed_q.size(), s);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return '0;
        if (r < 16) return DIM_W'($urandom_range(4097, 8191));
        if (r < 24) return DIM_W'($urandom_range(17, 4096));
        if (r < 28) return MAX_DIM;
        return DIM_W'($urandom_range(1, 12));
    endfunction

    task automatic send_macropixel(input macropixel_t mp, input bit typed,
                                   input plane_write_t want);
        known_t k;
        k.typed = typed;
        k.want  = want;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        known_q.insert(known_q.size(), k);
        s_tvalid <= 1'b1;
        s_tdata  <= mp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // registers change only once every pending write has drained
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (plane_q.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int send_pct[3] = '{18, 70, 0};
        int recv_pct[3] = '{70, 18, 0};
        int sent, burst;

        // reset geometry 640 x 480, top-left
        add_known(32'h0000_0000, 24'd0, 8'h00, 8'h00, 1'b1, 22'd0, 8'h00, 8'h00, 1'b1, 1'b0);
        add_known(32'hFFFF_FFFF, 24'd2, 8'hFF, 8'hFF, 1'b1, 22'd1, 8'hFF, 8'hFF, 1'b1, 1'b0);
        add_reg(REG_SPARE, 13'h1FFF);
        add_known(32'h1234_5678, 24'd4, 8'h78, 8'h34, 1'b1, 22'd2, 8'h56, 8'h12, 1'b1, 1'b0);
        // odd width, shrunk while the column is already past the new row end
        add_reg(REG_FRAME_WIDTH, 13'd5);
        add_reg(REG_FRAME_HEIGHT, 13'd2);
        add_pixel(32'hA55A_C33C);
        add_pixel(32'h0102_0304);
        add_pixel(32'hF0E1_D2C3);
        add_pixel(32'h8000_0080);
        add_pixel(32'h7F7F_7F7F);
        add_pixel(32'h5555_AAAA);
        add_pixel(32'hAAAA_5555);
        // zero dimensions act as 1 x 1: every macropixel closes a frame
        add_reg(REG_FRAME_WIDTH, 13'd0);
        add_reg(REG_FRAME_HEIGHT, 13'd0);
        add_pixel(32'h3CC3_5AA5);
        add_known(32'hA5C3_3CFF, 24'd0, 8'hFF, 8'h00, 1'b0, 22'd0, 8'h00, 8'h00, 1'b0, 1'b1);
        // all register bits set: clamps to the maximum
        add_reg(REG_FRAME_WIDTH, 13'h1FFF);
        add_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        add_pixel(32'hDEAD_BEEF);
        add_pixel(32'h0BAD_F00D);
        // maximum width, single row
        add_reg(REG_FRAME_WIDTH, MAX_DIM);
        add_reg(REG_FRAME_HEIGHT, 13'd1);
        add_pixel(32'hC001_D00D);
        add_pixel(32'h1357_9BDF);
        // narrow frame entered mid-row
        add_reg(REG_FRAME_WIDTH, 13'd2);
        add_reg(REG_FRAME_HEIGHT, 13'd3);
        add_pixel(32'h2468_ACE0);
        add_pixel(32'hFEDC_BA98);
        add_pixel(32'h7654_3210);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle = send_pct[0];
        recv_idle = recv_pct[0];
        foreach (directed_q[i]) begin
            if (directed_q[i].kind == STEP_REG)
                write_reg(directed_q[i].addr, directed_q[i].value);
            else
                send_macropixel(directed_q[i].mp, directed_q[i].typed, directed_q[i].want);
        end

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = send_pct[mode];
            recv_idle = recv_pct[mode];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                write_reg(REG_FRAME_WIDTH, pick_dim());
                write_reg(REG_FRAME_HEIGHT, pick_dim());
                burst = $urandom_range(1, 60);
                if (burst > PHASE_ITEMS - sent) burst = PHASE_ITEMS - sent;
                repeat (burst) send_macropixel(macropixel_t'($urandom()), 1'b0, '0);
                sent += burst;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (plane_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d macropixels and %0d plane writes (%0d chroma, %0d frame ends)",
                 n_macropixels, n_writes, n_chroma, n_frames);
        $display("over %0d register writes: odd, zero, clamped, full-size and mid-frame geometry",
                 n_reg_writes);
        if (n_mismatch == 0 && plane_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d writes never seen", n_mismatch, plane_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
